>>> rtl/slg_pkg.sv
`default_nettype none

package slg_pkg;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int LEVEL_W  = 22;
  localparam int PARAM_W  = 20;
  localparam int GAIN_W   = 20;
  localparam int OFFS_W   = 24;
  localparam int RATE_W   = 18;
  localparam int STEP_W   = 24;

  // apb
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [IDX_W-1:0] REG_RELEASE = 3'd1;
  localparam logic [IDX_W-1:0] REG_ATTEN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCALE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET  = 3'd4;
  localparam logic [IDX_W-1:0] REG_RATE    = 3'd5;

  localparam logic [PARAM_W-1:0] ATTACK_RST  = 20'd6554;
  localparam logic [PARAM_W-1:0] RELEASE_RST = 20'd45875;
  localparam logic [GAIN_W-1:0]  ATTEN_RST   = 20'd65536;
  localparam logic [GAIN_W-1:0]  SCALE_RST   = 20'd65536;
  localparam logic [OFFS_W-1:0]  OFFSET_RST  = 24'd0;
  localparam logic [RATE_W-1:0]  RATE_RST    = 18'd48000;

  // step size computation
  localparam int M_W    = 23;
  localparam int PW_W   = 18;
  localparam int K_W    = 4;
  localparam int X_W    = 24;
  localparam int DEN_W  = 52;
  localparam int NUM_W  = 52;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] NUM_C = 52'd10000 << 36;
  localparam logic [NUM_W-1:0] STEP_MAX = 52'd8388607;

  // item path
  localparam int SLEW_W = SAMPLE_W + 2;
  localparam int A_W    = SAMPLE_W + GAIN_W - 16;
  localparam int C_W    = A_W + GAIN_W - 16;
  localparam int B_W    = C_W + 1;
  localparam int FALL_SNAP  = 1049;
  localparam int GATE_LEVEL = 209716;
  localparam int ONE_Q20    = 1048576;

  typedef struct packed {
    logic [PARAM_W-1:0] attack_param;
    logic [PARAM_W-1:0] release_param;
    logic [GAIN_W-1:0]  atten_gain;
    logic [GAIN_W-1:0]  scale_gain;
    logic [OFFS_W-1:0]  level_offset;
    logic [RATE_W-1:0]  sample_rate;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_OUT,
    ST_PREP,
    ST_XMUL,
    ST_DMUL,
    ST_DINIT,
    ST_DIV,
    ST_STORE
  } state_e;

  typedef struct packed {
    logic sel;       // 0 rise step, 1 fall step
    logic prep;
    logic xmul;
    logic dmul;
    logic dinit;
    logic div_step;
    logic store;
    logic slew;
    logic mul1;
    logic mul2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // 2^(i/16) in Q16
  function automatic logic [PW_W-1:0] pow2_lut(input logic [4:0] i);
    logic [PW_W-1:0] v;
    v = '0;
    case (i)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      5'd16: v = 18'd131072;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/slg_regs.sv
`default_nettype none

module slg_regs import slg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              calc_ack_i,
  output logic                   calc_pend_o,
  output cfg_t                   cfg_o
);

  cfg_t             cfg_d, cfg_q;
  logic             pend_d, pend_q;
  logic             wr;
  logic             hit;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_ATTACK:  cfg_d.attack_param  = pwdata[PARAM_W-1:0];
        REG_RELEASE: cfg_d.release_param = pwdata[PARAM_W-1:0];
        REG_ATTEN:   cfg_d.atten_gain    = pwdata[GAIN_W-1:0];
        REG_SCALE:   cfg_d.scale_gain    = pwdata[GAIN_W-1:0];
        REG_OFFSET:  cfg_d.level_offset  = pwdata[OFFS_W-1:0];
        REG_RATE:    cfg_d.sample_rate   = pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // step sizes depend on attack, release and rate only
  always_comb begin
    case (idx) inside
      REG_ATTACK, REG_RELEASE, REG_RATE: hit = wr;
      default: hit = 1'b0;
    endcase
  end

  assign pend_d = hit ? 1'b1 : (calc_ack_i ? 1'b0 : pend_q);

  always_comb begin
    unique case (idx)
      REG_ATTACK:  prdata = DATA_W'(cfg_q.attack_param);
      REG_RELEASE: prdata = DATA_W'(cfg_q.release_param);
      REG_ATTEN:   prdata = DATA_W'(cfg_q.atten_gain);
      REG_SCALE:   prdata = DATA_W'(cfg_q.scale_gain);
      REG_OFFSET:  prdata = DATA_W'(cfg_q.level_offset);
      REG_RATE:    prdata = DATA_W'(cfg_q.sample_rate);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_param  <= ATTACK_RST;
      cfg_q.release_param <= RELEASE_RST;
      cfg_q.atten_gain    <= ATTEN_RST;
      cfg_q.scale_gain    <= SCALE_RST;
      cfg_q.level_offset  <= OFFSET_RST;
      cfg_q.sample_rate   <= RATE_RST;
      pend_q              <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      pend_q <= pend_d;
    end
  end

  assign cfg_o       = cfg_q;
  assign calc_pend_o = pend_q;

endmodule

`default_nettype wire

>>> rtl/slg_ctrl.sv
`default_nettype none

module slg_ctrl import slg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_tvalid_i,
  output logic      s_tready_o,
  input  wire logic calc_pend_i,
  output logic      calc_ack_o,
  input  status_t   status_i,
  output cmd_t      cmd_o
);

  state_e               state_d, state_q;
  logic                 sel_d, sel_q;
  logic [DIV_CNT_W-1:0] cnt_d, cnt_q;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (calc_pend_i) begin
          state_d = ST_PREP;
          sel_d   = 1'b0;
        end else if (s_tvalid_i) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_PREP:  state_d = ST_XMUL;
      ST_XMUL:  state_d = ST_DMUL;
      ST_DMUL:  state_d = ST_DINIT;
      ST_DINIT: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(NUM_W - 1)) state_d = ST_STORE;
      end
      ST_STORE: begin
        if (!sel_q) begin
          state_d = ST_PREP;
          sel_d   = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    s_tready_o = 1'b0;
    calc_ack_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o  = !calc_pend_i;
        calc_ack_o  = calc_pend_i;
        cmd_o.slew  = !calc_pend_i && s_tvalid_i;
      end
      ST_MUL1:  cmd_o.mul1     = 1'b1;
      ST_MUL2:  cmd_o.mul2     = 1'b1;
      ST_OUT:   cmd_o.out_load = status_i.out_free;
      ST_PREP:  cmd_o.prep     = 1'b1;
      ST_XMUL:  cmd_o.xmul     = 1'b1;
      ST_DMUL:  cmd_o.dmul     = 1'b1;
      ST_DINIT: cmd_o.dinit    = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_STORE: cmd_o.store    = 1'b1;
      default: ;
    endcase
  end

  // reset runs the step computation before the first item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PREP;
      sel_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/slg_dp.sv
`default_nettype none

module slg_dp import slg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  cfg_t                     cfg_i,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  wire logic [SAMPLE_W-1:0] sample_in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [LEVEL_W-1:0]  level_out_o,
  output logic                     gate_out_o
);

  // step computation signals
  logic [PARAM_W-1:0]    p;
  logic [16:0]           f;
  logic [18:0]           t5;
  logic [2:0]            seg;
  logic [15:0]           fr;
  logic [M_W-1:0]        m_d, m_q;
  logic [PARAM_W-1:0]    e;
  logic [3:0]            idx;
  logic [11:0]           r;
  logic [PW_W-1:0]       lo, hi;
  logic [12:0]           diff;
  logic [25:0]           ip;
  logic [PW_W-1:0]       pw_d, pw_q;
  logic [K_W-1:0]        k_q;
  logic [M_W+PW_W-1:0]   mp;
  logic [X_W-1:0]        x_q;
  logic [RATE_W-1:0]     rate_eff;
  logic [X_W+RATE_W-1:0] xr;
  logic [DEN_W-1:0]      den_q;
  logic [NUM_W-1:0]      num_q, quot_q;
  logic [DEN_W-1:0]      rem_q;
  logic [DEN_W:0]        trial;
  logic                  ge;
  logic [STEP_W-1:0]     step_val;
  logic [STEP_W-1:0]     rise_step_q, fall_step_q;

  // item path signals
  logic [SAMPLE_W-1:0]      held_d, held_q;
  logic signed [SLEW_W-1:0] h, tg, up, dn, nxt;
  logic                     moving;
  logic signed [SAMPLE_W+GAIN_W-1:0] prod_a;
  logic signed [A_W-1:0]    a_q;
  logic signed [A_W+GAIN_W-1:0] prod_b;
  logic signed [B_W-1:0]    b;
  logic [LEVEL_W-1:0]       sat;
  logic [LEVEL_W-1:0]       res_level_q, out_level_q;
  logic                     res_gate_q, out_gate_q, out_valid_q;

  // mintime in Q16 ms and the fractional power of two
  always_comb begin
    p   = cmd_i.sel ? cfg_i.release_param : cfg_i.attack_param;
    f   = (p > PARAM_W'(65536)) ? 17'd65536 : p[16:0];
    t5  = ({2'b00, f} << 2) + {2'b00, f};
    seg = t5[18:16];
    fr  = t5[15:0];
    case (seg)
      3'd0:    m_d = M_W'(65536);
      3'd1:    m_d = M_W'(65536) + M_W'(fr * 20'd9);
      3'd2:    m_d = M_W'(655360);
      3'd3:    m_d = M_W'(655360) + M_W'(fr * 23'd90);
      default: m_d = M_W'(6553600);
    endcase
    e    = (p > PARAM_W'(655360)) ? PARAM_W'(655360) : p;
    idx  = e[15:12];
    r    = e[11:0];
    lo   = pow2_lut({1'b0, idx});
    hi   = pow2_lut({1'b0, idx} + 5'd1);
    diff = 13'(hi - lo);
    ip   = 26'(diff) * 26'(r) + 26'd2048;
    pw_d = lo + PW_W'(ip[25:12]);
  end

  assign mp       = m_q * pw_q;
  assign rate_eff = (cfg_i.sample_rate == '0) ? RATE_W'(1) : cfg_i.sample_rate;
  assign xr       = x_q * rate_eff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    if (quot_q == '0) begin
      step_val = STEP_W'(1);
    end else if (quot_q > STEP_MAX) begin
      step_val = STEP_MAX[STEP_W-1:0];
    end else begin
      step_val = quot_q[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      m_q  <= m_d;
      pw_q <= pw_d;
      k_q  <= e[19:16];
    end
    if (cmd_i.xmul) x_q <= mp[X_W+15:16];
    if (cmd_i.dmul) den_q <= DEN_W'(xr) << k_q;
    if (cmd_i.dinit) begin
      num_q  <= NUM_C + (den_q >> 1);
      rem_q  <= '0;
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_q  <= num_q << 1;
      quot_q <= {quot_q[NUM_W-2:0], ge};
    end
    if (cmd_i.store) begin
      if (cmd_i.sel) fall_step_q <= step_val;
      else           rise_step_q <= step_val;
    end
  end

  // slew toward the target
  always_comb begin
    h   = $signed({{2{held_q[SAMPLE_W-1]}}, held_q});
    tg  = $signed({{2{sample_in_i[SAMPLE_W-1]}}, sample_in_i});
    up  = h + $signed({2'b00, rise_step_q});
    dn  = h - $signed({2'b00, fall_step_q});
    nxt = up;
    moving = 1'b0;
    if (tg > h) begin
      nxt    = up;
      moving = up < tg;
    end else if (tg < h) begin
      nxt    = dn;
      moving = (dn - tg) >= SLEW_W'(FALL_SNAP);
    end
    held_d = moving ? nxt[SAMPLE_W-1:0] : sample_in_i;
  end

  assign prod_a = $signed(held_q) * $signed(cfg_i.atten_gain);
  assign prod_b = a_q * $signed(cfg_i.scale_gain);
  assign b      = $signed({prod_b[A_W+GAIN_W-1], prod_b[A_W+GAIN_W-1:16]})
                + $signed({{(B_W-OFFS_W){cfg_i.level_offset[OFFS_W-1]}}, cfg_i.level_offset});

  always_comb begin
    if (b > B_W'(ONE_Q20)) begin
      sat = LEVEL_W'(ONE_Q20);
    end else if (b < -B_W'(ONE_Q20)) begin
      sat = LEVEL_W'(-ONE_Q20);
    end else begin
      sat = b[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) a_q <= prod_a[SAMPLE_W+GAIN_W-1:16];
    if (cmd_i.mul2) begin
      res_level_q <= sat;
      res_gate_q  <= b >= B_W'(GATE_LEVEL);
    end
    if (cmd_i.out_load) begin
      out_level_q <= res_level_q;
      out_gate_q  <= res_gate_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.slew) held_q <= held_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign level_out_o       = out_level_q;
  assign gate_out_o        = out_gate_q;

endmodule

`default_nettype wire

>>> rtl/slew_limiter_with_gate_top.sv
// slew limiter with gate output
//
// s_axis carries one signed q3.20 target sample per transaction. the held
// level moves toward it by at most the rise step, or by less than the fall
// step plus FALL_SNAP, and m_axis returns the level scaled by two q3.16
// gains, offset and saturated to +-1.0, with the gate flag on tuser set
// when that result is at least 0.2. the apb port holds six registers at
// byte addresses 0 to 20; writing attack, release or sample rate starts a
// step recompute (two passes of a 52-bit bit-serial divider and setup), during
// which s_axis_tready stays low. reset runs the same recompute with the
// reset values before the first sample is taken.
// one sample at a time: each accepted sample runs the slew update, the two
// gain multiplies and the load of the output register in sequence before
// the next sample is taken.
// the result sits in an output register; a stalled receiver holds it, the
// next sample is still accepted and its result waits until the register
// frees up.
`default_nettype none

module slew_limiter_with_gate_top import slg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // apb configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [SAMPLE_W-1:0] s_axis_tdata,   // [23:0] sample_in
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [23:0]         m_axis_tdata,   // [21:0] level_out, [23:22] zero
  output logic                     m_axis_tuser    // [0] gate_out
);

  cfg_t               cfg;
  cmd_t               cmd;
  status_t            status;
  logic               calc_pend;
  logic               calc_ack;
  logic [LEVEL_W-1:0] level_out;

  slg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .calc_ack_i  (calc_ack),
    .calc_pend_o (calc_pend),
    .cfg_o       (cfg)
  );

  slg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .calc_pend_i (calc_pend),
    .calc_ack_o  (calc_ack),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  slg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_in_i (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .level_out_o (level_out),
    .gate_out_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, level_out};

endmodule

`default_nettype wire

>>> rtl/slg_checker.sv
`default_nettype none

module slg_checker import slg_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00 &&
      $signed(m_axis_tdata[21:0]) <= ONE_Q20 &&
      $signed(m_axis_tdata[21:0]) >= -ONE_Q20)
    else $error("level out of saturation range");

  a_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ($signed(m_axis_tdata[21:0]) >= GATE_LEVEL))
    else $error("gate does not match level");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while busy");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |-> ##4 m_axis_tvalid)
    else $error("result late");

endmodule

bind slew_limiter_with_gate_top slg_checker u_slg_checker (.*);

`default_nettype wire

>>> sim/slew_limiter_with_gate_top_test.sv
`timescale 1ns / 1ps

module slew_limiter_with_gate_top_test;
  import slg_pkg::*;

  // register indexes with no register behind them
  localparam logic [IDX_W-1:0] REG_HOLE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_HOLE_B = 3'd7;
  localparam longint SAMPLE_MAX = 8388607;
  localparam longint SAMPLE_MIN = -8388608;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               gate;
  } level_res_t;

  logic clk;
  logic rst_n;

  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                in_valid;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] in_data;

  logic                m_axis_tvalid;
  logic                out_ready;
  logic [23:0]         m_axis_tdata;
  logic                m_axis_tuser;

  // predictor state
  cfg_t               pred_cfg;
  longint             pred_held;
  logic [STEP_W-1:0]  pred_rise;
  logic [STEP_W-1:0]  pred_fall;
  level_res_t         expected_levels[$];

  int in_gap_pct;
  int out_stall_pct;
  int out_hold_cycles;
  int n_errors;
  int n_sent;
  int n_checked;
  int n_writes;

  slew_limiter_with_gate_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit [63:0] pow2_q16(input bit [4:0] i);
    case (i)
      5'd0:    return 65536;
      5'd1:    return 68438;
      5'd2:    return 71468;
      5'd3:    return 74632;
      5'd4:    return 77936;
      5'd5:    return 81386;
      5'd6:    return 84990;
      5'd7:    return 88752;
      5'd8:    return 92682;
      5'd9:    return 96785;
      5'd10:   return 101070;
      5'd11:   return 105545;
      5'd12:   return 110218;
      5'd13:   return 115098;
      5'd14:   return 120194;
      5'd15:   return 125515;
      default: return 131072;
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] slew_step_size(input logic [PARAM_W-1:0] p,
                                                       input logic [RATE_W-1:0] rate);
    bit [63:0] f, t, seg, fr, mt, e, k, g, idx, r, pw, x, rt, den, q;
    if (p > 65536) f = 65536;
    else f = p;
    t = 5 * f;
    seg = t >> 16;
    fr = t & 64'hFFFF;
    // minimum time in ms, piecewise over the five segments
    if (seg == 0) mt = 65536;
    else if (seg == 1) mt = 65536 + 9 * fr;
    else if (seg == 2) mt = 655360;
    else if (seg == 3) mt = 655360 + 90 * fr;
    else mt = 6553600;
    if (p > 655360) e = 655360;
    else e = p;
    k = e >> 16;
    g = e & 64'hFFFF;
    idx = g >> 12;
    r = g & 64'hFFF;
    pw = pow2_q16(idx[4:0]) +
         (((pow2_q16(idx[4:0] + 5'd1) - pow2_q16(idx[4:0])) * r + 2048) >> 12);
    x = (mt * pw) >> 16;
    if (rate == 0) rt = 1;
    else rt = rate;
    den = (x * rt) << k;
    q = ((64'd10000 << 36) + den / 2) / den;
    if (q < 1) q = 1;
    if (q > 8388607) q = 8388607;
    return q[STEP_W-1:0];
  endfunction

  function automatic void refresh_steps();
    pred_rise = slew_step_size(pred_cfg.attack_param, pred_cfg.sample_rate);
    pred_fall = slew_step_size(pred_cfg.release_param, pred_cfg.sample_rate);
  endfunction

  function automatic void reset_predictor();
    pred_cfg.attack_param  = ATTACK_RST;
    pred_cfg.release_param = RELEASE_RST;
    pred_cfg.atten_gain    = ATTEN_RST;
    pred_cfg.scale_gain    = SCALE_RST;
    pred_cfg.level_offset  = OFFSET_RST;
    pred_cfg.sample_rate   = RATE_RST;
    pred_held = 0;
    refresh_steps();
  endfunction

  function automatic level_res_t apply_sample(input logic [SAMPLE_W-1:0] s);
    longint tgt, delta, ga, gs, offs, a, b;
    bit moving;
    level_res_t res;
    tgt = $signed(s);
    ga = $signed(pred_cfg.atten_gain);
    gs = $signed(pred_cfg.scale_gain);
    offs = $signed(pred_cfg.level_offset);
    delta = tgt - pred_held;
    moving = 1'b0;
    if (delta > 0) begin
      pred_held = pred_held + pred_rise;
      moving = pred_held < tgt;
    end else if (delta < 0) begin
      pred_held = pred_held - pred_fall;
      moving = (pred_held - tgt) >= FALL_SNAP;
    end
    if (!moving) pred_held = tgt;
    a = (pred_held * ga) >>> 16;
    b = ((a * gs) >>> 16) + offs;
    if (b > ONE_Q20) b = ONE_Q20;
    if (b < -ONE_Q20) b = -ONE_Q20;
    res.level = b[LEVEL_W-1:0];
    res.gate = (b >= GATE_LEVEL);
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] to_sample(input longint v);
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  // mostly targets within a few steps of the held level so snaps happen often
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int unsigned sel;
    longint span, off;
    sel = $urandom_range(9);
    if (sel < 3) return SAMPLE_W'($urandom);
    if (sel == 3) return to_sample(pred_held);
    if (sel == 9) begin
      case ($urandom_range(2))
        0:       return to_sample(SAMPLE_MAX);
        1:       return to_sample(SAMPLE_MIN);
        default: return '0;
      endcase
    end
    span = (pred_rise > pred_fall) ? pred_rise : pred_fall;
    span = span * 2 + 2100;
    off = $urandom_range(32'(span * 2));
    return to_sample(pred_held + off - span);
  endfunction

  // receiver side: random stalls, or a counted hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold_cycles > 0) begin
        out_ready <= 1'b0;
        out_hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_out
    level_res_t want;
    if (rst_n && m_axis_tvalid && out_ready) begin
      n_checked++;
      if (expected_levels.size() == 0) begin
        $error("level_out %0d arrived with no sample pending",
               $signed(m_axis_tdata[LEVEL_W-1:0]));
        n_errors++;
      end else begin
        want = expected_levels.pop_front();
        if (m_axis_tdata[LEVEL_W-1:0] !== want.level) begin
          $error("level_out mismatch: expected %0d, got %0d", $signed(want.level),
                 $signed(m_axis_tdata[LEVEL_W-1:0]));
          n_errors++;
        end
        if (m_axis_tuser !== want.gate) begin
          $error("gate_out mismatch: expected %0d, got %0d", want.gate, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata[23:LEVEL_W] !== '0) begin
          $error("tdata pad mismatch: expected 0, got %0d", m_axis_tdata[23:LEVEL_W]);
          n_errors++;
        end
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    level_res_t res;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    res = apply_sample(v);
    expected_levels.push_back(res);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    n_writes++;
    case (idx)
      REG_ATTACK: begin
        pred_cfg.attack_param = value[PARAM_W-1:0];
        refresh_steps();
      end
      REG_RELEASE: begin
        pred_cfg.release_param = value[PARAM_W-1:0];
        refresh_steps();
      end
      REG_ATTEN:  pred_cfg.atten_gain = value[GAIN_W-1:0];
      REG_SCALE:  pred_cfg.scale_gain = value[GAIN_W-1:0];
      REG_OFFSET: pred_cfg.level_offset = value[OFFS_W-1:0];
      REG_RATE: begin
        pred_cfg.sample_rate = value[RATE_W-1:0];
        refresh_steps();
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    // step recompute holds off the input stream until it is done
    if (idx == REG_ATTACK || idx == REG_RELEASE || idx == REG_RATE) begin
      repeat (2) @(negedge clk);
      while (!s_axis_tready) @(negedge clk);
    end
  endtask

  task automatic randomize_settings();
    logic [DATA_W-1:0] v;
    if ($urandom_range(3) == 0) v = $urandom;
    else v = $urandom_range(655360);
    write_reg(REG_ATTACK, v);
    if ($urandom_range(3) == 0) v = $urandom;
    else v = $urandom_range(655360);
    write_reg(REG_RELEASE, v);
    if ($urandom_range(1) == 0) v = $urandom;
    else v = $urandom_range(196608) - 98304;
    write_reg(REG_ATTEN, v);
    if ($urandom_range(1) == 0) v = $urandom;
    else v = $urandom_range(196608) - 98304;
    write_reg(REG_SCALE, v);
    if ($urandom_range(1) == 0) v = $urandom;
    else v = $urandom_range(524288) - 262144;
    write_reg(REG_OFFSET, v);
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = $urandom_range(262143);
      default: v = $urandom_range(192000, 8000);
    endcase
    write_reg(REG_RATE, v);
  endtask

  // rise and fall paths at reset settings, with targets placed on the snap edges
  task automatic test_slew_directions();
    in_gap_pct = 20;
    out_stall_pct = 20;
    send_sample('0);
    send_sample(to_sample(pred_held + pred_rise + 1));
    send_sample(to_sample(pred_held + pred_rise));
    send_sample(to_sample(SAMPLE_MAX));
    send_sample(to_sample(SAMPLE_MIN));
    send_sample(to_sample(pred_held - pred_fall - FALL_SNAP));
    send_sample(to_sample(pred_held - pred_fall - (FALL_SNAP - 1)));
    send_sample(to_sample(pred_held));
    wait_drained();
  endtask

  task automatic test_setting_extremes();
    // zero times and zero rate: step clamps at its maximum
    write_reg(REG_ATTACK, '0);
    write_reg(REG_RELEASE, '0);
    write_reg(REG_RATE, '0);
    send_sample(to_sample(SAMPLE_MAX));
    send_sample(to_sample(SAMPLE_MIN));
    send_sample(to_sample(GATE_LEVEL));
    send_sample(to_sample(GATE_LEVEL - 1));
    wait_drained();
    // gains at their extremes drive the output into saturation
    write_reg(REG_ATTEN, 32'h0008_0000);
    write_reg(REG_SCALE, 32'h0008_0000);
    send_sample(to_sample(SAMPLE_MAX));
    send_sample(to_sample(SAMPLE_MIN));
    send_sample(to_sample(SAMPLE_MIN));
    wait_drained();
    write_reg(REG_ATTEN, 32'h0007_FFFF);
    send_sample(to_sample(SAMPLE_MAX));
    wait_drained();
    write_reg(REG_OFFSET, 32'h007F_FFFF);
    send_sample('0);
    wait_drained();
    write_reg(REG_OFFSET, 32'hFF80_0000);
    send_sample(to_sample(1));
    wait_drained();
    // settings above range and the top rate: step clamps at one lsb
    write_reg(REG_ATTACK, 32'hFFFF_FFFF);
    write_reg(REG_RELEASE, 32'd655360);
    write_reg(REG_RATE, 32'd262143);
    send_sample(to_sample(pred_held + 5));
    send_sample(to_sample(pred_held - 2000));
    wait_drained();
    write_reg(REG_HOLE_A, 32'hFFFF_FFFF);
    write_reg(REG_HOLE_B, $urandom);
    send_sample(to_sample(pred_held + 3));
    wait_drained();
  endtask

  task automatic test_backpressure();
    in_gap_pct = 0;
    out_stall_pct = 0;
    out_hold_cycles = 300;
    repeat (16) send_sample(next_sample());
    wait_drained();
    repeat (8) send_sample(next_sample());
    wait_drained();
    repeat (8) send_sample(next_sample());
    wait_drained();
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    repeat (6) begin
      randomize_settings();
      repeat (105) send_sample(next_sample());
      wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    out_hold_cycles = 0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_writes = 0;
    reset_predictor();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_slew_directions();
    test_setting_extremes();
    test_backpressure();
    test_random_traffic(35, 64);
    test_random_traffic(64, 35);
    test_random_traffic(0, 0);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("checked %0d levels from %0d samples across %0d register writes",
             n_checked, n_sent, n_writes);
    $display("covered snaps both ways, step clamps, saturation, gate edge and backpressure");
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
